// File: src/otq_pkg.sv
// otq_pkg: types, codes and constants shared by the ordered timer queue
// no dependencies; imported by every module of the block
package otq_pkg;

    localparam int NUM_TIMERS_DEF   = 16;
    localparam int SIGNAL_WIDTH_DEF = 16;

    localparam int SLOT_W = 4;
    localparam int EXP_W  = 32;
    localparam int SIG_W  = 16;

    localparam logic signed [EXP_W-1:0] ND_EMPTY  = -32'sd1;
    localparam logic [EXP_W-1:0]        DELAY_MAX = 32'h7FFF_FFFF;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_INS,
        ST_ND,
        ST_ACK,
        ST_FIRE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DEQ,
        CELL_POP,
        CELL_INS
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [SLOT_W-1:0]  key_slot;
        logic [EXP_W-1:0]   key_exp;
    } t_cell_ctl;

    typedef struct packed {
        logic               head_valid;
        logic               head_due;
        logic               second_due;
        logic               full;
        logic               gt_any;
        logic [SLOT_W-1:0]  head_slot;
        logic [EXP_W-1:0]   head_exp;
        logic [EXP_W-1:0]   gt_exp;
    } t_chain_stat;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [SLOT_W-1:0]  slot;
        logic [EXP_W-1:0]   delay;
        logic [SIG_W-1:0]   signal;
        logic [EXP_W-1:0]   time_now;
    } t_cmd;

    typedef struct packed {
        logic [1:0]               kind;
        logic                     status;
        logic [SLOT_W-1:0]        fired_slot;
        logic [SIG_W-1:0]         fired_signal;
        logic signed [EXP_W-1:0]  next_delay;
        logic                     last;
    } t_result;

endpackage

// File: src/otq_cell.sv
// otq_cell: one queue position holding slot, expiry and signal word
// depends on otq_pkg; instantiated in a row by otq_chain
module otq_cell #(
    parameter int SIGNAL_WIDTH = otq_pkg::SIGNAL_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  otq_pkg::t_cell_ctl             i_ctl,
    input  logic [SIGNAL_WIDTH-1:0]        i_new_sig,
    input  logic                           i_left_valid,
    input  logic [otq_pkg::SLOT_W-1:0]     i_left_slot,
    input  logic [otq_pkg::EXP_W-1:0]      i_left_exp,
    input  logic [SIGNAL_WIDTH-1:0]        i_left_sig,
    input  logic                           i_left_le,
    input  logic                           i_match_in,
    input  logic                           i_right_valid,
    input  logic [otq_pkg::SLOT_W-1:0]     i_right_slot,
    input  logic [otq_pkg::EXP_W-1:0]      i_right_exp,
    input  logic [SIGNAL_WIDTH-1:0]        i_right_sig,
    output logic                           o_valid,
    output logic [otq_pkg::SLOT_W-1:0]     o_slot,
    output logic [otq_pkg::EXP_W-1:0]      o_exp,
    output logic [SIGNAL_WIDTH-1:0]        o_sig,
    output logic                           o_le,
    output logic                           o_match_out
);
    import otq_pkg::*;

    logic                    r_valid, n_valid;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [EXP_W-1:0]        r_exp, n_exp;
    logic [SIGNAL_WIDTH-1:0] r_sig, n_sig;
    logic                    match;

    assign match       = r_valid && (r_slot == i_ctl.key_slot);
    assign o_match_out = i_match_in | match;
    assign o_le        = r_valid && (r_exp <= i_ctl.key_exp);

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        n_exp   = r_exp;
        n_sig   = r_sig;
        case (i_ctl.op)
            CELL_DEQ: begin
                // close the gap left by the removed entry
                if (o_match_out) begin
                    n_valid = i_right_valid;
                    n_slot  = i_right_slot;
                    n_exp   = i_right_exp;
                    n_sig   = i_right_sig;
                end
            end
            CELL_POP: begin
                n_valid = i_right_valid;
                n_slot  = i_right_slot;
                n_exp   = i_right_exp;
                n_sig   = i_right_sig;
            end
            CELL_INS: begin
                // earlier or equal expiries stay, the first later one makes room
                if (!o_le) begin
                    if (i_left_le) begin
                        n_valid = 1'b1;
                        n_slot  = i_ctl.key_slot;
                        n_exp   = i_ctl.key_exp;
                        n_sig   = i_new_sig;
                    end else begin
                        n_valid = i_left_valid;
                        n_slot  = i_left_slot;
                        n_exp   = i_left_exp;
                        n_sig   = i_left_sig;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_exp  <= n_exp;
        r_sig  <= n_sig;
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;
    assign o_exp   = r_exp;
    assign o_sig   = r_sig;

endmodule

// File: src/otq_chain.sv
// otq_chain: row of otq_cell, ordered by expiry with the head at position 0
// depends on otq_pkg and otq_cell
module otq_chain #(
    parameter int NUM_TIMERS   = otq_pkg::NUM_TIMERS_DEF,
    parameter int SIGNAL_WIDTH = otq_pkg::SIGNAL_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  otq_pkg::t_cell_ctl      i_ctl,
    input  logic [SIGNAL_WIDTH-1:0] i_new_sig,
    output otq_pkg::t_chain_stat    o_stat,
    output logic [SIGNAL_WIDTH-1:0] o_head_sig
);
    import otq_pkg::*;

    logic                    v     [NUM_TIMERS];
    logic [SLOT_W-1:0]       slot  [NUM_TIMERS];
    logic [EXP_W-1:0]        expv  [NUM_TIMERS];
    logic [SIGNAL_WIDTH-1:0] sig   [NUM_TIMERS];
    logic                    le    [NUM_TIMERS];
    logic                    mo    [NUM_TIMERS];
    logic                    first_gt [NUM_TIMERS];
    logic                    gt_any;
    logic [EXP_W-1:0]        gt_exp;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
            logic                    lv, lle, lmi, rv;
            logic [SLOT_W-1:0]       ls, rs;
            logic [EXP_W-1:0]        le_x, re_x;
            logic [SIGNAL_WIDTH-1:0] lsig, rsig;

            if (g == 0) begin : g_first
                assign lv   = 1'b0;
                assign ls   = '0;
                assign le_x = '0;
                assign lsig = '0;
                assign lle  = 1'b1;
                assign lmi  = 1'b0;
            end else begin : g_mid
                assign lv   = v[g-1];
                assign ls   = slot[g-1];
                assign le_x = expv[g-1];
                assign lsig = sig[g-1];
                assign lle  = le[g-1];
                assign lmi  = mo[g-1];
            end

            if (g == NUM_TIMERS - 1) begin : g_end
                assign rv   = 1'b0;
                assign rs   = '0;
                assign re_x = '0;
                assign rsig = '0;
            end else begin : g_inner
                assign rv   = v[g+1];
                assign rs   = slot[g+1];
                assign re_x = expv[g+1];
                assign rsig = sig[g+1];
            end

            // first entry past the key: everything left of it is due
            assign first_gt[g] = v[g] && !le[g] && lle;

            otq_cell #(
                .SIGNAL_WIDTH(SIGNAL_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_new_sig    (i_new_sig),
                .i_left_valid (lv),
                .i_left_slot  (ls),
                .i_left_exp   (le_x),
                .i_left_sig   (lsig),
                .i_left_le    (lle),
                .i_match_in   (lmi),
                .i_right_valid(rv),
                .i_right_slot (rs),
                .i_right_exp  (re_x),
                .i_right_sig  (rsig),
                .o_valid      (v[g]),
                .o_slot       (slot[g]),
                .o_exp        (expv[g]),
                .o_sig        (sig[g]),
                .o_le         (le[g]),
                .o_match_out  (mo[g])
            );
        end

        if (NUM_TIMERS > 1) begin : g_second
            assign o_stat.second_due = le[1];
        end else begin : g_single
            assign o_stat.second_due = 1'b0;
        end
    endgenerate

    always_comb begin
        gt_any = 1'b0;
        gt_exp = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            gt_any = gt_any | first_gt[i];
            gt_exp = gt_exp | (first_gt[i] ? expv[i] : '0);
        end
    end

    assign o_stat.gt_any     = gt_any;
    assign o_stat.gt_exp     = gt_exp;
    assign o_stat.head_valid = v[0];
    assign o_stat.head_due   = le[0];
    assign o_stat.full       = v[NUM_TIMERS-1];
    assign o_stat.head_slot  = slot[0];
    assign o_stat.head_exp   = expv[0];
    assign o_head_sig        = sig[0];

endmodule

// File: src/ordered_timer_queue.sv
// ordered_timer_queue: top level with command sequencer and result register
// depends on otq_pkg and otq_chain
//
// usage:
//   a command transaction is taken at a clock edge with start high and busy low;
//   i_cmd carries the command code, slot, delay, signal word and new time.
//   results leave on o_res, each for one cycle with o_strobe high; the receiver
//   cannot hold them off. o_res.last marks the final result of a command.
// order of steps (accept edge to result strobe):
//   add: dequeue, insert, next-delay, ack; remove: dequeue, next-delay, ack;
//   unused code: next-delay, ack; tick: next-delay, then one fired timer per
//   cycle; busy stays high until the last result is registered, so a new
//   command can start in the cycle the last result shows. steps: dequeue
//   shift, ordered insert, head/next-delay evaluation, one pop per fired timer.
// reset: synchronous active-low; clears the current time, every cell valid bit
//   and the sequencer, leaving an empty queue.
module ordered_timer_queue #(
    parameter int NUM_TIMERS   = otq_pkg::NUM_TIMERS_DEF,
    parameter int SIGNAL_WIDTH = otq_pkg::SIGNAL_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  otq_pkg::t_cmd    i_cmd,
    output otq_pkg::t_result o_res,
    output logic             o_strobe
);
    import otq_pkg::*;

    t_state                  r_state, n_state;
    t_cmd_code               r_cmd, n_cmd;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [SIGNAL_WIDTH-1:0] r_sig, n_sig;
    logic [EXP_W-1:0]        r_e, n_e;
    logic [EXP_W-1:0]        r_cur, n_cur;
    logic                    r_status, n_status;
    logic signed [EXP_W-1:0] r_nd, n_nd;
    t_result                 r_res, n_res;
    logic                    r_strobe, n_strobe;

    t_cell_ctl               ctl;
    t_chain_stat             stat;
    logic [SIGNAL_WIDTH-1:0] head_sig;

    logic                    slot_ok;
    logic                    sel_valid, sel_due;
    logic [EXP_W-1:0]        sel_exp, diff;
    logic signed [EXP_W-1:0] nd_calc;

    otq_chain #(
        .NUM_TIMERS  (NUM_TIMERS),
        .SIGNAL_WIDTH(SIGNAL_WIDTH)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_new_sig (r_sig),
        .o_stat    (stat),
        .o_head_sig(head_sig)
    );

    assign slot_ok = (7'(r_slot) < 7'(NUM_TIMERS));

    // tick: next expiry is the first entry that stays; otherwise the head
    always_comb begin
        sel_valid = (r_cmd == CMD_TICK) ? stat.gt_any : stat.head_valid;
        sel_exp   = (r_cmd == CMD_TICK) ? stat.gt_exp : stat.head_exp;
        sel_due   = (r_cmd != CMD_TICK) && stat.head_due;
        diff      = sel_exp - r_cur;
        if (!sel_valid) begin
            nd_calc = ND_EMPTY;
        end else if (sel_due) begin
            nd_calc = '0;
        end else if (diff[EXP_W-1]) begin
            nd_calc = signed'(DELAY_MAX);
        end else begin
            nd_calc = signed'(diff);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_sig        = r_sig;
        n_e          = r_e;
        n_cur        = r_cur;
        n_status     = r_status;
        n_nd         = r_nd;
        n_res        = '0;
        n_strobe     = 1'b0;
        ctl.op       = CELL_HOLD;
        ctl.key_slot = r_slot;
        ctl.key_exp  = r_cur;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd    = t_cmd_code'(i_cmd.cmd);
                    n_slot   = i_cmd.slot;
                    n_sig    = SIGNAL_WIDTH'(i_cmd.signal);
                    n_e      = r_cur + i_cmd.delay;
                    n_status = STATUS_OK;
                    unique case (t_cmd_code'(i_cmd.cmd))
                        CMD_ADD, CMD_REMOVE: n_state = ST_DEQ;
                        CMD_TICK: begin
                            n_cur   = i_cmd.time_now;
                            n_state = ST_ND;
                        end
                        CMD_NOP: n_state = ST_ND;
                    endcase
                end
            end
            ST_DEQ: begin
                // a slot out of range is never in the row, so the shift is a no-op
                ctl.op  = CELL_DEQ;
                n_state = (r_cmd == CMD_ADD) ? ST_INS : ST_ND;
            end
            ST_INS: begin
                ctl.key_exp = r_e;
                if (slot_ok && !stat.full) begin
                    ctl.op = CELL_INS;
                end else begin
                    n_status = STATUS_REJECT;
                end
                n_state = ST_ND;
            end
            ST_ND: begin
                n_nd    = nd_calc;
                n_state = (r_cmd == CMD_TICK) ? ST_FIRE : ST_ACK;
            end
            ST_ACK: begin
                n_strobe         = 1'b1;
                n_res.kind       = KIND_ACK;
                n_res.status     = r_status;
                n_res.next_delay = r_nd;
                n_res.last       = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_FIRE: begin
                n_strobe         = 1'b1;
                n_res.next_delay = r_nd;
                if (stat.head_due) begin
                    ctl.op             = CELL_POP;
                    n_res.kind         = KIND_FIRED;
                    n_res.fired_slot   = stat.head_slot;
                    n_res.fired_signal = SIG_W'(head_sig);
                    n_res.last         = !stat.second_due;
                    if (!stat.second_due) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_res.kind = KIND_NONE;
                    n_res.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_slot   <= n_slot;
        r_sig    <= n_sig;
        r_e      <= n_e;
        r_status <= n_status;
        r_nd     <= n_nd;
        r_res    <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_res    = r_res;
    assign o_strobe = r_strobe;

endmodule

// File: src/otq_checker.sv
// otq_checker: port-level assertions for ordered_timer_queue
// depends on otq_pkg; attached to the top level by the bind at the end
module otq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input otq_pkg::t_result o_res,
    input logic             o_strobe
);
    import otq_pkg::*;

    // an accepted command always raises busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // a burst of fired timers comes out without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |=> o_strobe)
        else $error("gap inside a result burst");

    // only fired-timer results can be followed by more results
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.kind != KIND_FIRED) |-> o_res.last)
        else $error("non-fired result without last");

    // the final result frees the command port
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.last |-> !busy)
        else $error("busy still high with final result");

    // a tick that fired nothing leaves nothing due
    a_none_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.kind == KIND_NONE) |-> (o_res.next_delay != 0))
        else $error("quiet tick reports a due timer");

endmodule

bind ordered_timer_queue otq_checker u_otq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_res   (o_res),
    .o_strobe(o_strobe)
);
